// File: rtl/ema_alert_pkg.sv
// Shared types, codes and helpers for the per-channel moving average alert block.
`timescale 1ns / 1ps

package ema_alert_pkg;

	// command codes on the cmd port
	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_NOP    = 2'd3;

	// reason codes
	localparam logic [1:0] RSN_NONE       = 2'd0;
	localparam logic [1:0] RSN_FACTUALITY = 2'd1;
	localparam logic [1:0] RSN_REFUSAL    = 2'd2;
	localparam logic [1:0] RSN_LATENCY    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_ALPHA     = 2'd0;
	localparam logic [1:0] CFG_MIN_COUNT = 2'd1;
	localparam logic [1:0] CFG_LEVEL     = 2'd2;

	// Q1.16 unity and counter ceiling
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	// register reset values
	localparam logic [16:0] ALPHA_RST = 17'd6554;
	localparam logic [31:0] MIN_RST   = 32'd10;
	localparam logic [16:0] LEVEL_RST = 17'd32768;

	// one channel entry of the table
	typedef struct packed {
		logic        valid;
		logic [15:0] avg;
		logic [15:0] prev;
		logic [31:0] samples;
		logic [31:0] fact;
		logic [31:0] refu;
		logic [31:0] lat;
	} entry_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture input word, read table
		logic exec;      // update entry and register the result
		logic sweep;     // invalidate one entry, step sweep pointer
		logic zero_res;  // register an all-zero result
	} dp_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic in_clear;    // word on the input is a clear
		logic sweep_last;  // sweep pointer at last entry
	} dp_sts_t;

	// saturating increment
	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		logic [31:0] r;
		r = (v == CNT_MAX) ? v : v + 32'd1;
		return r;
	endfunction

endpackage

// File: rtl/per_channel_ema_quality_alert_top.sv
// Top level of the per-channel moving average quality alert block.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low; its result is shown for
// exactly one cycle with done high and cannot be held off. For record, query
// and no-operation words the accept edge captures the word and reads the channel
// table, then the exec state updates the entry and registers the result, and a
// new word may be taken in the cycle done is high. A clear word sweeps the
// table one entry per cycle to drop every valid flag. After reset busy stays
// high for the same sweep; configuration writes are taken at any time.
module per_channel_ema_quality_alert_top
	import ema_alert_pkg::*;
#(
	parameter int CHANNELS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [5:0]         channel,
	input  logic [15:0]        score,
	input  logic [1:0]         reason_code,
	output logic               done,
	output logic               found,
	output logic [15:0]        average,
	output logic signed [16:0] change,
	output logic [31:0]        sample_count,
	output logic               alert,
	output logic [31:0]        factuality_count,
	output logic [31:0]        refusal_count,
	output logic [31:0]        latency_count
);

	dp_ctl_t ctl;
	dp_sts_t sts;

	ema_alert_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	ema_alert_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.channel          (channel),
		.score            (score),
		.reason_code      (reason_code),
		.ctl              (ctl),
		.sts              (sts),
		.found            (found),
		.average          (average),
		.change           (change),
		.sample_count     (sample_count),
		.alert            (alert),
		.factuality_count (factuality_count),
		.refusal_count    (refusal_count),
		.latency_count    (latency_count)
	);

	// a taken word always moves the block out of idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after a word was taken");

	// the result strobe only shows while idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a missing channel reports no samples
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (sample_count == 32'd0 && !alert))
		else $error("non-zero trend for an unknown channel");

	// a known channel has at least one sample
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (sample_count != 32'd0))
		else $error("known channel with zero samples");

endmodule

// File: rtl/ema_alert_ctrl.sv
// Sequencer for the moving average block: start-up sweep, update and clear.
`timescale 1ns / 1ps

module ema_alert_ctrl
	import ema_alert_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output dp_ctl_t ctl,
	output logic    busy,
	output logic    done
);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP
	} state_t;

	state_t state_q;
	logic   done_q;

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					if (sts.sweep_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start)
						state_q <= sts.in_clear ? ST_SWEEP : ST_EXEC;
				end
				ST_EXEC: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (sts.sweep_last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

	// datapath commands
	always_comb begin
		ctl          = '0;
		ctl.load     = (state_q == ST_IDLE) && start;
		ctl.exec     = (state_q == ST_EXEC);
		ctl.sweep    = (state_q == ST_INIT) || (state_q == ST_SWEEP);
		ctl.zero_res = (state_q == ST_SWEEP) && sts.sweep_last;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// File: rtl/ema_alert_dp.sv
// Datapath: config registers, channel table, average update and result registers.
`timescale 1ns / 1ps

module ema_alert_dp
	import ema_alert_pkg::*;
#(
	parameter int CHANNELS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [1:0]         cmd,
	input  logic [5:0]         channel,
	input  logic [15:0]        score,
	input  logic [1:0]         reason_code,
	input  dp_ctl_t            ctl,
	output dp_sts_t            sts,
	output logic               found,
	output logic [15:0]        average,
	output logic signed [16:0] change,
	output logic [31:0]        sample_count,
	output logic               alert,
	output logic [31:0]        factuality_count,
	output logic [31:0]        refusal_count,
	output logic [31:0]        latency_count
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// config
	logic [16:0] alpha_q;
	logic [31:0] min_q;
	logic [16:0] level_q;

	// captured word
	logic [1:0]    cmd_q;
	logic [CW-1:0] idx_q;
	logic [15:0]   score_q;
	logic [1:0]    reason_q;
	logic          rng_q;

	// table
	entry_t        mem_q [CHANNELS];
	entry_t        rd_q;
	logic [CW-1:0] sweep_q;

	// result registers
	logic        found_q;
	logic [15:0] avg_q;
	logic [16:0] chg_q;
	logic [31:0] cnt_q;
	logic        alert_q;
	logic [31:0] fact_q;
	logic [31:0] refu_q;
	logic [31:0] lat_q;

	logic [31:0]        ch_ext;
	logic [CW-1:0]      in_idx;
	logic               in_rng;
	logic [16:0]        a_sat;
	logic signed [16:0] diff;
	logic signed [34:0] prod;
	logic signed [34:0] mix;
	entry_t             base;
	entry_t             nxt;
	entry_t             res;
	logic               wr_rec;
	logic               show;
	logic               mem_we;
	logic [CW-1:0]      mem_addr;
	entry_t             mem_wdata;

	// input index and range check
	assign ch_ext = {26'd0, channel};
	assign in_idx = ch_ext[CW-1:0];
	assign in_rng = (ch_ext < 32'(CHANNELS));

	assign sts.in_clear   = (cmd == CMD_CLEAR);
	assign sts.sweep_last = (sweep_q == CW'(CHANNELS - 1));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			min_q   <= MIN_RST;
			level_q <= LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALPHA:     alpha_q <= cfg_data[16:0];
				CFG_MIN_COUNT: min_q   <= cfg_data;
				CFG_LEVEL:     level_q <= cfg_data[16:0];
				default:       ;
			endcase
		end
	end

	// sweep pointer, wraps after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sweep_q <= '0;
		else if (ctl.sweep)
			sweep_q <= sts.sweep_last ? '0 : sweep_q + CW'(1);
	end

	// average step: old + floor(a * (score - old) / 2^16)
	always_comb begin
		a_sat = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;
		diff  = $signed({1'b0, score_q}) - $signed({1'b0, rd_q.avg});
		prod  = $signed({1'b0, a_sat}) * diff;
		mix   = $signed({19'd0, rd_q.avg}) + (prod >>> 16);
	end

	// next entry and result selection
	always_comb begin
		if (rd_q.valid) begin
			base      = rd_q;
			base.prev = rd_q.avg;
			base.avg  = mix[15:0];
		end else begin
			base       = '0;
			base.valid = 1'b1;
			base.avg   = score_q;
			base.prev  = score_q;
		end
		nxt         = base;
		nxt.samples = sat_inc(base.samples);
		case (reason_q)
			RSN_FACTUALITY: nxt.fact = sat_inc(base.fact);
			RSN_REFUSAL:    nxt.refu = sat_inc(base.refu);
			RSN_LATENCY:    nxt.lat  = sat_inc(base.lat);
			default:        ;
		endcase

		wr_rec = ctl.exec && rng_q && (cmd_q == CMD_RECORD);
		show   = rng_q && ((cmd_q == CMD_RECORD) || ((cmd_q == CMD_QUERY) && rd_q.valid));
		res    = (cmd_q == CMD_RECORD) ? nxt : rd_q;

		mem_we    = wr_rec || ctl.sweep;
		mem_addr  = ctl.sweep ? sweep_q : idx_q;
		mem_wdata = ctl.sweep ? entry_t'('0) : nxt;
	end

	// table port and captured word
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_addr] <= mem_wdata;
		if (ctl.load) begin
			rd_q     <= mem_q[in_idx];
			cmd_q    <= cmd;
			idx_q    <= in_idx;
			score_q  <= score;
			reason_q <= reason_code;
			rng_q    <= in_rng;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (ctl.exec && show) begin
			found_q <= 1'b1;
			avg_q   <= res.avg;
			chg_q   <= {1'b0, res.avg} - {1'b0, res.prev};
			cnt_q   <= res.samples;
			alert_q <= (res.samples >= min_q) && ({1'b0, res.avg} < level_q);
			fact_q  <= res.fact;
			refu_q  <= res.refu;
			lat_q   <= res.lat;
		end else if (ctl.exec || ctl.zero_res) begin
			found_q <= 1'b0;
			avg_q   <= '0;
			chg_q   <= '0;
			cnt_q   <= '0;
			alert_q <= 1'b0;
			fact_q  <= '0;
			refu_q  <= '0;
			lat_q   <= '0;
		end
	end

	assign found            = found_q;
	assign average          = avg_q;
	assign change           = $signed(chg_q);
	assign sample_count     = cnt_q;
	assign alert            = alert_q;
	assign factuality_count = fact_q;
	assign refusal_count    = refu_q;
	assign latency_count    = lat_q;

endmodule

// File: bench/per_channel_ema_quality_alert_top_tb.sv
// Self-checking bench for the per-channel moving average quality alert block.
`timescale 1ns / 1ps

module per_channel_ema_quality_alert_top_tb;
	import ema_alert_pkg::*;

	localparam int NCH         = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 6;
	localparam int PHASE_WORDS = 165;

	// one result word as seen on the result ports
	typedef struct packed {
		logic        found;
		logic [15:0] avg;
		logic [16:0] delta;
		logic [31:0] count;
		logic        alert;
		logic [31:0] fact;
		logic [31:0] refu;
		logic [31:0] lat;
	} trend_t;

	localparam trend_t NO_TREND = '0;

	// directed rows: checked by the model copy, typed in by hand, or a register write
	typedef enum logic [1:0] {ROW_CHECKED, ROW_TYPED, ROW_CFG} row_kind_t;

	// for a register write, op holds the register index and val the data
	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  op;
		logic [5:0]  ch;
		logic [31:0] val;
		logic [1:0]  rsn;
		trend_t      want;
	} plan_row_t;

	localparam int PLAN_ROWS = 35;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_TYPED,   CMD_QUERY,  6'd0,  32'd0,      RSN_NONE,       NO_TREND},
		'{ROW_TYPED,   CMD_NOP,    6'd5,  32'd777,    RSN_LATENCY,    NO_TREND},
		'{ROW_TYPED,   CMD_RECORD, 6'd0,  32'd0,      RSN_NONE,
			'{1'b1, 16'd0, 17'd0, 32'd1, 1'b0, 32'd0, 32'd0, 32'd0}},
		'{ROW_CHECKED, CMD_RECORD, 6'd0,  32'hFFFF,   RSN_FACTUALITY, NO_TREND},
		'{ROW_TYPED,   CMD_RECORD, 6'd63, 32'hFFFF,   RSN_REFUSAL,
			'{1'b1, 16'hFFFF, 17'd0, 32'd1, 1'b0, 32'd0, 32'd1, 32'd0}},
		'{ROW_CHECKED, CMD_RECORD, 6'd63, 32'd0,      RSN_LATENCY,    NO_TREND},
		'{ROW_CHECKED, CMD_QUERY,  6'd63, 32'd0,      RSN_NONE,       NO_TREND},
		'{ROW_TYPED,   CMD_RECORD, 6'd1,  32'hAAAA,   RSN_LATENCY,
			'{1'b1, 16'hAAAA, 17'd0, 32'd1, 1'b0, 32'd0, 32'd0, 32'd1}},
		'{ROW_CHECKED, CMD_RECORD, 6'd1,  32'h5555,   RSN_NONE,       NO_TREND},
		'{ROW_TYPED,   CMD_CLEAR,  6'd9,  32'h1234,   RSN_REFUSAL,    NO_TREND},
		'{ROW_TYPED,   CMD_QUERY,  6'd0,  32'd0,      RSN_NONE,       NO_TREND},
		'{ROW_TYPED,   CMD_QUERY,  6'd63, 32'd0,      RSN_NONE,       NO_TREND},
		// first sample after a clear restarts every counter
		'{ROW_TYPED,   CMD_RECORD, 6'd0,  32'd1234,   RSN_FACTUALITY,
			'{1'b1, 16'd1234, 17'd0, 32'd1, 1'b0, 32'd1, 32'd0, 32'd0}},
		'{ROW_CFG,     CFG_ALPHA,     6'd0, 32'd0,        RSN_NONE, NO_TREND},
		'{ROW_CFG,     CFG_MIN_COUNT, 6'd0, 32'd0,        RSN_NONE, NO_TREND},
		'{ROW_CFG,     CFG_LEVEL,     6'd0, 32'd65536,    RSN_NONE, NO_TREND},
		// zero weight: the average holds, alert at once with no minimum
		'{ROW_TYPED,   CMD_RECORD, 6'd0,  32'hFFFF,   RSN_REFUSAL,
			'{1'b1, 16'd1234, 17'd0, 32'd2, 1'b1, 32'd1, 32'd1, 32'd0}},
		// weight above one acts as one
		'{ROW_CFG,     CFG_ALPHA,     6'd0, 32'h0001FFFF, RSN_NONE, NO_TREND},
		'{ROW_CFG,     CFG_LEVEL,     6'd0, 32'd0,        RSN_NONE, NO_TREND},
		'{ROW_CHECKED, CMD_RECORD, 6'd0,  32'd40000,  RSN_LATENCY,    NO_TREND},
		'{ROW_CHECKED, CMD_RECORD, 6'd0,  32'd0,      RSN_NONE,       NO_TREND},
		'{ROW_CFG,     CFG_ALPHA,     6'd0, 32'd65536,    RSN_NONE, NO_TREND},
		'{ROW_CFG,     CFG_MIN_COUNT, 6'd0, 32'hFFFFFFFF, RSN_NONE, NO_TREND},
		'{ROW_CFG,     CFG_LEVEL,     6'd0, 32'h0001FFFF, RSN_NONE, NO_TREND},
		'{ROW_CHECKED, CMD_QUERY,  6'd0,  32'd0,      RSN_NONE,       NO_TREND},
		'{ROW_TYPED,   CMD_RECORD, 6'd2,  32'hFFFF,   RSN_FACTUALITY,
			'{1'b1, 16'hFFFF, 17'd0, 32'd1, 1'b0, 32'd1, 32'd0, 32'd0}},
		'{ROW_CFG,     CFG_ALPHA,     6'd0, 32'd6554,     RSN_NONE, NO_TREND},
		'{ROW_CFG,     CFG_MIN_COUNT, 6'd0, 32'd2,        RSN_NONE, NO_TREND},
		'{ROW_CFG,     CFG_LEVEL,     6'd0, 32'd32768,    RSN_NONE, NO_TREND},
		'{ROW_CHECKED, CMD_RECORD, 6'd3,  32'd100,    RSN_NONE,       NO_TREND},
		'{ROW_CHECKED, CMD_RECORD, 6'd3,  32'd100,    RSN_REFUSAL,    NO_TREND},
		'{ROW_TYPED,   CMD_QUERY,  6'd1,  32'd0,      RSN_NONE,       NO_TREND},
		'{ROW_TYPED,   CMD_NOP,    6'd63, 32'hFFFF,   RSN_LATENCY,    NO_TREND},
		'{ROW_TYPED,   CMD_CLEAR,  6'd0,  32'd0,      RSN_NONE,       NO_TREND},
		'{ROW_TYPED,   CMD_QUERY,  6'd3,  32'd0,      RSN_NONE,       NO_TREND}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic [5:0]         channel;
	logic [15:0]        score;
	logic [1:0]         reason_code;
	logic               done;
	logic               found;
	logic [15:0]        average;
	logic signed [16:0] change;
	logic [31:0]        sample_count;
	logic               alert;
	logic [31:0]        factuality_count;
	logic [31:0]        refusal_count;
	logic [31:0]        latency_count;

	// model copy of the channel table and registers
	logic [63:0] ch_live;
	logic [15:0] ch_mean      [NCH];
	logic [15:0] ch_last_mean [NCH];
	logic [31:0] ch_samples   [NCH];
	logic [31:0] ch_fact      [NCH];
	logic [31:0] ch_refusal   [NCH];
	logic [31:0] ch_latency   [NCH];
	logic [16:0] alpha_w;
	logic [31:0] min_samples_w;
	logic [16:0] level_w;

	trend_t trend_q [$];
	int     mismatches;
	int     quiet_cycles;

	per_channel_ema_quality_alert_top #(.CHANNELS(NCH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.channel(channel),
		.score(score),
		.reason_code(reason_code),
		.done(done),
		.found(found),
		.average(average),
		.change(change),
		.sample_count(sample_count),
		.alert(alert),
		.factuality_count(factuality_count),
		.refusal_count(refusal_count),
		.latency_count(latency_count)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

	// advance the table copy by one word and return the trend it reports
	function automatic trend_t predict_trend(input logic [1:0] op, input logic [5:0] ch,
			input logic [15:0] sc, input logic [1:0] rsn);
		trend_t      t;
		logic [16:0] w;
		logic [63:0] mix;
		t = '0;
		case (op)
			CMD_CLEAR: begin
				ch_live = '0;
			end
			CMD_RECORD, CMD_QUERY: begin
				if (op == CMD_RECORD) begin
					if (!ch_live[ch]) begin
						// first sample seeds both averages and restarts the counters
						ch_mean[ch]      = sc;
						ch_last_mean[ch] = sc;
						ch_samples[ch]   = '0;
						ch_fact[ch]      = '0;
						ch_refusal[ch]   = '0;
						ch_latency[ch]   = '0;
						ch_live[ch]      = 1'b1;
					end else begin
						w = (alpha_w > ONE_Q16) ? ONE_Q16 : alpha_w;
						mix = 64'(w) * 64'(sc) + 64'(ONE_Q16 - w) * 64'(ch_mean[ch]);
						ch_last_mean[ch] = ch_mean[ch];
						ch_mean[ch]      = mix[31:16];
					end
					ch_samples[ch] = bump(ch_samples[ch]);
					case (rsn)
						RSN_FACTUALITY: ch_fact[ch]    = bump(ch_fact[ch]);
						RSN_REFUSAL:    ch_refusal[ch] = bump(ch_refusal[ch]);
						RSN_LATENCY:    ch_latency[ch] = bump(ch_latency[ch]);
						default: ;
					endcase
				end
				if (ch_live[ch]) begin
					t.found = 1'b1;
					t.avg   = ch_mean[ch];
					t.delta = {1'b0, ch_mean[ch]} - {1'b0, ch_last_mean[ch]};
					t.count = ch_samples[ch];
					t.alert = (ch_samples[ch] >= min_samples_w) &&
						({1'b0, ch_mean[ch]} < level_w);
					t.fact  = ch_fact[ch];
					t.refu  = ch_refusal[ch];
					t.lat   = ch_latency[ch];
				end
			end
			default: ;
		endcase
		return t;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
			mismatches++;
		end
	endfunction

	// mostly short gaps, a few long ones, none in steady stretches
	function automatic int pick_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	// register write once every expected word is back; no word is offered meanwhile
	task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
		start <= 1'b0;
		while (trend_q.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_ALPHA:     alpha_w       = val[16:0];
			CFG_MIN_COUNT: min_samples_w = val;
			CFG_LEVEL:     level_w       = val[16:0];
			default: ;
		endcase
	endtask

	// offer one word, wait until busy is low again, then queue its expected result
	task automatic send_word(input logic [1:0] op, input logic [5:0] ch,
			input logic [15:0] sc, input logic [1:0] rsn, input int gap,
			input bit typed, input trend_t typed_want);
		trend_t t;
		cfg_we <= 1'b0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		cmd         <= op;
		channel     <= ch;
		score       <= sc;
		reason_code <= rsn;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		t = predict_trend(op, ch, sc, rsn);
		trend_q.insert(trend_q.size(), typed ? typed_want : t);
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		trend_t seen;
		trend_t want;
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (done) begin
				seen = '{found, average, change, sample_count, alert,
					factuality_count, refusal_count, latency_count};
				if (trend_q.size() == 0) begin
					$display("%0t: result word with none expected", $time);
					mismatches++;
				end else begin
					want = trend_q.pop_front();
					compare_field("found", want.found, seen.found);
					compare_field("average", want.avg, seen.avg);
					compare_field("change", want.delta, seen.delta);
					compare_field("sample_count", want.count, seen.count);
					compare_field("alert", want.alert, seen.alert);
					compare_field("factuality_count", want.fact, seen.fact);
					compare_field("refusal_count", want.refu, seen.refu);
					compare_field("latency_count", want.lat, seen.lat);
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		logic [5:0]  hot [4];
		logic [1:0]  op;
		logic [5:0]  ch;
		logic [15:0] sc;
		logic [31:0] v;
		bit          steady;
		int          r;

		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_ALPHA;
		cfg_data      = '0;
		start         = 1'b0;
		cmd           = CMD_NOP;
		channel       = '0;
		score         = '0;
		reason_code   = RSN_NONE;
		mismatches    = 0;
		quiet_cycles  = 0;
		ch_live       = '0;
		alpha_w       = ALPHA_RST;
		min_samples_w = MIN_RST;
		level_w       = LEVEL_RST;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_CFG)
				write_register(PLAN[i].op, PLAN[i].val);
			else
				send_word(PLAN[i].op, PLAN[i].ch, PLAN[i].val[15:0], PLAN[i].rsn,
					pick_gap(1'b0), PLAN[i].kind == ROW_TYPED, PLAN[i].want);
		end

		// random phases, each under its own register settings
		for (int p = 0; p < PHASES; p++) begin
			r = $urandom_range(0, 4);
			case (r)
				0: v = 32'd0;
				1: v = 32'd65536;
				2: v = $urandom_range(65537, 131071);
				3: v = $urandom_range(1, 4096);
				default: v = $urandom_range(1, 65535);
			endcase
			write_register(CFG_ALPHA, ($urandom & 32'hFFFE_0000) | v);
			r = $urandom_range(0, 5);
			v = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom_range(1, 16);
			write_register(CFG_MIN_COUNT, v);
			r = $urandom_range(0, 5);
			case (r)
				0: v = 32'd0;
				1: v = 32'd65536;
				2: v = 32'h0001_FFFF;
				default: v = $urandom_range(0, 65535);
			endcase
			write_register(CFG_LEVEL, ($urandom & 32'hFFFE_0000) | v);

			// a few hot channels so averages and counts build up
			foreach (hot[k])
				hot[k] = 6'($urandom_range(0, NCH - 1));
			steady = ($urandom_range(0, 2) == 0);

			for (int n = 0; n < PHASE_WORDS; n++) begin
				r = $urandom_range(0, 99);
				op = (r < 62) ? CMD_RECORD : (r < 90) ? CMD_QUERY :
					(r < 98) ? CMD_NOP : CMD_CLEAR;
				ch = ($urandom_range(0, 99) < 85) ? hot[$urandom_range(0, 3)] :
					6'($urandom_range(0, NCH - 1));
				r = $urandom_range(0, 99);
				sc = (r < 12) ? 16'd0 : (r < 24) ? 16'hFFFF : 16'($urandom_range(0, 65535));
				send_word(op, ch, sc, 2'($urandom_range(0, 3)), pick_gap(steady),
					1'b0, NO_TREND);
			end
		end

		// drain and allow for stray words
		start <= 1'b0;
		while (trend_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
